// ===== hw/rtl/bbs_pkg.sv =====
package bbs_pkg;

  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 7;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 8;
  localparam int CMD_W = 3;
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [CMD_W-1:0] CMD_PUSH = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_POP = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_PEEK = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_DUMP_DOWN = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_DUMP_UP = CMD_W'(4);

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_DUMP_DOWN,
    OP_DUMP_UP
  } op_t;

  typedef struct packed {
    op_t op;
    logic [DATA_W-1:0] value;
  } cmd_entry_t;

  typedef struct packed {
    logic avail;
    cmd_entry_t entry;
  } front_req_t;

endpackage

// ===== hw/rtl/bbs_ram.sv =====
module bbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bbs_front.sv =====
module bbs_front import bbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [CMD_W-1:0] command,
  input  logic [DATA_W-1:0] push_value,
  output front_req_t req,
  input  logic take
);

  cmd_entry_t q_entry [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic known;
  op_t op;
  logic push_q;
  logic pop_q;

  always_comb begin
    known = 1'b1;
    op = OP_PUSH;
    case (command)
      CMD_PUSH: op = OP_PUSH;
      CMD_POP: op = OP_POP;
      CMD_PEEK: op = OP_PEEK;
      CMD_DUMP_DOWN: op = OP_DUMP_DOWN;
      CMD_DUMP_UP: op = OP_DUMP_UP;
      default: known = 1'b0;
    endcase
  end

  assign busy = (count == QCNT_W'(QDEPTH));
  assign push_q = start && !busy && known;
  assign pop_q = take && (count != '0);
  assign req.avail = (count != '0);
  assign req.entry = q_entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push_q && !pop_q) begin
      count_next = count + QCNT_W'(1);
    end else if (pop_q && !push_q) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push_q) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop_q) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_entry[wr_ptr] <= '{op: op, value: push_value};
    end
  end

endmodule

// ===== hw/rtl/bbs_back.sv =====
module bbs_back import bbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  front_req_t req,
  output logic take,
  input  logic cfg_valid,
  input  logic [CAP_W-1:0] cfg_data,
  output logic [DATA_W-1:0] entry_value,
  output logic last,
  output logic result_valid
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] fill_dec;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_next;
  logic [AW-1:0] top;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] remain_next;
  logic down;
  logic down_next;
  logic [LIM_W-1:0] limit;
  logic push_ok;
  logic we;
  logic [AW-1:0] rd_addr;
  logic rd_fire;
  logic rd_last;

  assign fill_dec = fill - CNT_W'(1);
  assign top = fill_dec[AW-1:0];
  assign limit = (LIM_W'(capacity) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(capacity);
  assign push_ok = LIM_W'(fill) < limit;

  always_comb begin
    state_next = state;
    fill_next = fill;
    addr_next = addr;
    remain_next = remain;
    down_next = down;
    take = 1'b0;
    we = 1'b0;
    rd_addr = addr;
    rd_fire = 1'b0;
    rd_last = 1'b0;
    case (state)
      ST_RUN: begin
        if (req.avail) begin
          take = 1'b1;
          case (req.entry.op)
            OP_PUSH: begin
              if (push_ok) begin
                we = 1'b1;
                fill_next = fill + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (fill != '0) begin
                fill_next = fill_dec;
              end
            end
            OP_PEEK: begin
              if (fill != '0) begin
                rd_addr = top;
                rd_fire = 1'b1;
                rd_last = 1'b1;
              end
            end
            OP_DUMP_DOWN: begin
              if (fill != '0) begin
                rd_addr = top;
                rd_fire = 1'b1;
                rd_last = (fill == CNT_W'(1));
                addr_next = top - AW'(1);
                remain_next = fill_dec;
                down_next = 1'b1;
                if (fill != CNT_W'(1)) begin
                  state_next = ST_DUMP;
                end
              end
            end
            OP_DUMP_UP: begin
              if (fill != '0) begin
                rd_addr = '0;
                rd_fire = 1'b1;
                rd_last = (fill == CNT_W'(1));
                addr_next = AW'(1);
                remain_next = fill_dec;
                down_next = 1'b0;
                if (fill != CNT_W'(1)) begin
                  state_next = ST_DUMP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        rd_addr = addr;
        rd_fire = 1'b1;
        rd_last = (remain == CNT_W'(1));
        addr_next = down ? addr - AW'(1) : addr + AW'(1);
        remain_next = remain - CNT_W'(1);
        if (remain == CNT_W'(1)) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      fill <= '0;
      capacity <= CAP_RESET;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      result_valid <= rd_fire;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    remain <= remain_next;
    down <= down_next;
    last <= rd_last;
  end

  bbs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(fill[AW-1:0]),
    .wdata(req.entry.value),
    .raddr(rd_addr),
    .rdata(entry_value)
  );

endmodule

// ===== hw/rtl/bounded_byte_stack.sv =====
// Push, pop and peek are taken one request per cycle outside dumps; a peek result is
// registered from the stack RAM, behind any requests still waiting in the two-entry queue.
// A dump holds the execution unit until it has read each held entry from the stack RAM.
// Results cannot be stalled; result_valid marks each one for a single cycle.
// Synchronous reset empties the stack, flushes the queue and sets capacity to 64.
module bounded_byte_stack import bbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [CMD_W-1:0] command,
  input  logic [DATA_W-1:0] push_value,
  output logic result_valid,
  output logic [DATA_W-1:0] entry_value,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  front_req_t req;
  logic take;

  assign cfg_ready = 1'b1;

  bbs_front u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .push_value(push_value),
    .req(req),
    .take(take)
  );

  bbs_back u_back (
    .clk(clk),
    .rst(rst),
    .req(req),
    .take(take),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .entry_value(entry_value),
    .last(last),
    .result_valid(result_valid)
  );

endmodule

// ===== hw/rtl/bbs_checker.sv =====
module bbs_checker import bbs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic result_valid,
  input logic last
);

  // A dump delivers its entries back to back until the one marked last.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("dump results are not contiguous");

  assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid)
    else $error("last flag raised without a result");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

  assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

endmodule

bind bounded_byte_stack bbs_checker u_bbs_checker (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .result_valid(result_valid),
  .last(last)
);
